>>> hdl/ncc_pkg.sv
// Package for the nearest-centroid confusion counter.
// Holds sizes, operation codes, controller states, item types and helpers.
// No dependencies.
package ncc_pkg;

  localparam int NUM_CLASSES = 6;
  localparam int SAMPLE_BITS = 12;
  localparam int COUNT_BITS  = 16;
  localparam int OP_BITS     = 2;
  localparam int CLASS_BITS  = 3;
  localparam int SQUARE_BITS = 2 * SAMPLE_BITS;
  localparam int DIST_BITS   = SQUARE_BITS + 2;
  localparam int CELL_COUNT  = NUM_CLASSES * NUM_CLASSES;
  localparam int CELL_BITS   = $clog2(CELL_COUNT);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [OP_BITS-1:0] {
    OP_LOAD     = 2'd0,
    OP_CLASSIFY = 2'd1,
    OP_READ     = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_CLEAR,
    S_DIST,
    S_DRAIN,
    S_LOOKUP,
    S_WAIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [OP_BITS-1:0]     operation;
    logic [SAMPLE_BITS-1:0] sample_x;
    logic [SAMPLE_BITS-1:0] sample_y;
    logic [SAMPLE_BITS-1:0] sample_z;
    logic [CLASS_BITS-1:0]  true_class;
    logic [CLASS_BITS-1:0]  entry_index;
  } in_item_t;

  typedef struct packed {
    logic [CLASS_BITS-1:0] predicted_class;
    logic [COUNT_BITS-1:0] count_value;
    logic                  bad_label;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic step;
    logic load_centroid;
    logic clear_counts;
    logic lookup;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic last_centroid;
    logic out_free;
  } dp_sts_t;

  function automatic logic [CELL_BITS-1:0] cell_addr(input logic [CLASS_BITS-1:0] row,
                                                     input logic [CLASS_BITS-1:0] col);
    logic [CELL_BITS-1:0] r;
    r = CELL_BITS'(row);
    return r * CELL_BITS'(NUM_CLASSES) + CELL_BITS'(col);
  endfunction

endpackage

>>> hdl/nearest_centroid_confusion_counter.sv
// Nearest-centroid classifier that counts its predictions in a confusion
// matrix. A classify item visits the six centroids one per cycle through a
// single registered squared-distance unit, then reads, bumps and writes the
// chosen counter in the registered confusion memory if its true class is in
// range. Results sit in an output register, so a new item is taken while the
// last result waits. Reset and the clear operation empty the matrix at once
// through one valid bit per counter; centroids reset to zero. Uses ncc_pkg,
// ncc_ctrl and ncc_datapath.
module nearest_centroid_confusion_counter
  import ncc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      sample_valid,
  output logic      sample_ready,
  input  in_item_t  sample,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  ncc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_op    (sample.operation),
    .sample_ready (sample_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  ncc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

>>> hdl/ncc_ctrl.sv
// Controller state machine for the nearest-centroid confusion counter.
// Sequences the datapath through commands and reads its status; uses ncc_pkg.
module ncc_ctrl
  import ncc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  input  logic [OP_BITS-1:0]  sample_op,
  output logic                sample_ready,
  input  dp_sts_t             sts,
  output dp_cmd_t             cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    sample_ready = 1'b0;
    case (state)
      S_IDLE: begin
        sample_ready = !rst;
        if (sample_valid && !rst) begin
          cmd.capture = 1'b1;
          case (sample_op)
            OP_LOAD:     state_next = S_LOAD;
            OP_CLASSIFY: state_next = S_DIST;
            OP_READ:     state_next = S_LOOKUP;
            OP_CLEAR:    state_next = S_CLEAR;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd.load_centroid = 1'b1;
        state_next        = S_FINISH;
      end
      S_CLEAR: begin
        cmd.clear_counts = 1'b1;
        state_next       = S_FINISH;
      end
      S_DIST: begin
        cmd.step = 1'b1;
        if (sts.last_centroid) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/ncc_datapath.sv
// Datapath for the nearest-centroid confusion counter: item register,
// centroid registers, distance unit, confusion memory and result register.
// Uses ncc_pkg; driven by ncc_ctrl.
module ncc_datapath
  import ncc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  sample,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  in_item_t item;

  logic [SAMPLE_BITS-1:0] cent_x [NUM_CLASSES];
  logic [SAMPLE_BITS-1:0] cent_y [NUM_CLASSES];
  logic [SAMPLE_BITS-1:0] cent_z [NUM_CLASSES];

  logic [CLASS_BITS-1:0]  cidx;
  logic [SAMPLE_BITS-1:0] dx;
  logic [SAMPLE_BITS-1:0] dy;
  logic [SAMPLE_BITS-1:0] dz;
  logic [SQUARE_BITS-1:0] sq_x;
  logic [SQUARE_BITS-1:0] sq_y;
  logic [SQUARE_BITS-1:0] sq_z;
  logic                   sq_valid;
  logic [CLASS_BITS-1:0]  sq_idx;
  logic [DIST_BITS-1:0]   dist_sum;
  logic [DIST_BITS-1:0]   best_dist;
  logic [CLASS_BITS-1:0]  best;

  logic [COUNT_BITS-1:0] counts [CELL_COUNT];
  logic [CELL_COUNT-1:0] count_vld;
  logic [CELL_BITS-1:0]  rd_addr;
  logic [CELL_BITS-1:0]  wr_addr;
  logic [COUNT_BITS-1:0] cell_q;
  logic                  cell_vld;

  logic                  row_ok;
  logic                  col_ok;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] incr;
  logic                  do_write;
  out_item_t             res;

  assign row_ok = item.true_class < CLASS_BITS'(NUM_CLASSES);
  assign col_ok = item.entry_index < CLASS_BITS'(NUM_CLASSES);

  assign sts.last_centroid = cidx == CLASS_BITS'(NUM_CLASSES - 1);
  assign sts.out_free      = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        cent_x[i] <= '0;
        cent_y[i] <= '0;
        cent_z[i] <= '0;
      end
    end else if (cmd.load_centroid && col_ok) begin
      cent_x[item.entry_index] <= item.sample_x;
      cent_y[item.entry_index] <= item.sample_y;
      cent_z[item.entry_index] <= item.sample_z;
    end
  end

  always_comb begin
    dx = (item.sample_x >= cent_x[cidx]) ? item.sample_x - cent_x[cidx]
                                         : cent_x[cidx] - item.sample_x;
    dy = (item.sample_y >= cent_y[cidx]) ? item.sample_y - cent_y[cidx]
                                         : cent_y[cidx] - item.sample_y;
    dz = (item.sample_z >= cent_z[cidx]) ? item.sample_z - cent_z[cidx]
                                         : cent_z[cidx] - item.sample_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cidx     <= '0;
      sq_valid <= 1'b0;
    end else begin
      sq_valid <= cmd.step;
      if (cmd.capture) begin
        cidx <= '0;
      end else if (cmd.step) begin
        cidx <= cidx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      sq_x   <= SQUARE_BITS'(dx) * SQUARE_BITS'(dx);
      sq_y   <= SQUARE_BITS'(dy) * SQUARE_BITS'(dy);
      sq_z   <= SQUARE_BITS'(dz) * SQUARE_BITS'(dz);
      sq_idx <= cidx;
    end
  end

  assign dist_sum = DIST_BITS'(sq_x) + DIST_BITS'(sq_y) + DIST_BITS'(sq_z);

  always_ff @(posedge clk) begin
    if (sq_valid && (sq_idx == '0 || dist_sum < best_dist)) begin
      best_dist <= dist_sum;
      best      <= sq_idx;
    end
  end

  always_comb begin
    rd_addr = '0;
    if (item.operation == OP_CLASSIFY) begin
      if (row_ok) begin
        rd_addr = cell_addr(item.true_class, best);
      end
    end else if (row_ok && col_ok) begin
      rd_addr = cell_addr(item.true_class, item.entry_index);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      cell_q  <= counts[rd_addr];
      wr_addr <= rd_addr;
    end
    if (do_write) begin
      counts[wr_addr] <= incr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_vld <= '0;
      cell_vld  <= 1'b0;
    end else begin
      if (cmd.lookup) begin
        cell_vld <= count_vld[rd_addr];
      end
      if (cmd.clear_counts) begin
        count_vld <= '0;
      end else if (do_write) begin
        count_vld[wr_addr] <= 1'b1;
      end
    end
  end

  assign cur  = cell_vld ? cell_q : '0;
  assign incr = (cur == COUNT_MAX) ? cur : cur + 1'b1;

  always_comb begin
    res      = '0;
    do_write = 1'b0;
    case (item.operation)
      OP_CLASSIFY: begin
        res.predicted_class = best;
        if (row_ok) begin
          res.count_value = incr;
          do_write        = cmd.finish;
        end else begin
          res.bad_label = 1'b1;
        end
      end
      OP_READ: begin
        if (row_ok && col_ok) begin
          res.count_value = cur;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result <= res;
    end
  end

endmodule
